// ===== rtl/dlmd_pkg.sv =====
// Shared constants, register codes and defaults of the DoG local maximum detector.
`timescale 1ns / 1ps
package dlmd_pkg;

  localparam int DLMD_MAX_WIDTH    = 1024;
  localparam int DLMD_SAMPLE_BITS  = 16;
  localparam int DLMD_MAX_HEIGHT   = 1024;

  // Row counter and reported coordinates are fixed at ten bits.
  localparam int DLMD_ROW_BITS     = 10;
  localparam int DLMD_COORD_BITS   = 10;

  // Width and height registers are eleven bits, the threshold sixteen.
  localparam int DLMD_SIZE_BITS    = 11;
  localparam int DLMD_THR_BITS     = 16;

  localparam int DLMD_ADDR_BITS    = 4;
  localparam int DLMD_DATA_BITS    = 32;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CONTRAST_THR = 2'd2;

  localparam logic [DLMD_SIZE_BITS-1:0] FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [DLMD_SIZE_BITS-1:0] FRAME_HEIGHT_RESET = 11'd1024;
  localparam logic [DLMD_THR_BITS-1:0]  CONTRAST_THR_RESET = 16'd0;

  localparam int DLMD_MIN_SIZE     = 3;

  // 3x3x3 window, flattened as layer*9 + row*3 + col.
  localparam int DLMD_TAPS         = 27;
  localparam int DLMD_CENTRE_TAP   = 13;
  localparam int DLMD_LAYERS       = 3;

endpackage

// ===== rtl/dlmd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module dlmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [WIDTH-1:0]    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dlmd_max_check.sv =====
// Compares the window centre against its 26 neighbors and the contrast threshold.
`timescale 1ns / 1ps
module dlmd_max_check #(
  parameter int SAMPLE_BITS = dlmd_pkg::DLMD_SAMPLE_BITS
) (
  input  logic [dlmd_pkg::DLMD_TAPS*SAMPLE_BITS-1:0] window_i,
  input  logic signed [SAMPLE_BITS-1:0]              threshold_i,
  output logic                                       hit_o
);

  logic signed [SAMPLE_BITS-1:0] centre;
  logic                          is_max;
  logic signed [SAMPLE_BITS+2:0] centre_ext;
  logic signed [SAMPLE_BITS+2:0] thr_ext;
  logic signed [SAMPLE_BITS+2:0] centre_x5;
  logic signed [SAMPLE_BITS+2:0] thr_x4;

  assign centre = signed'(window_i[dlmd_pkg::DLMD_CENTRE_TAP*SAMPLE_BITS +: SAMPLE_BITS]);

  // Ties pass, so comparing the centre with itself is harmless.
  always_comb begin
    is_max = 1'b1;
    for (int t = 0; t < dlmd_pkg::DLMD_TAPS; t++) begin
      if (centre < signed'(window_i[t*SAMPLE_BITS +: SAMPLE_BITS])) begin
        is_max = 1'b0;
      end
    end
  end

  assign centre_ext = {{3{centre[SAMPLE_BITS-1]}}, centre};
  assign thr_ext    = {{3{threshold_i[SAMPLE_BITS-1]}}, threshold_i};
  assign centre_x5  = (centre_ext <<< 2) + centre_ext;
  assign thr_x4     = thr_ext <<< 2;

  assign hit_o = is_max && (centre_x5 >= thr_x4);

endmodule

// ===== rtl/dog_local_max_detector_core.sv =====
// Top level: 3x3x3 DoG scale-space local maximum detector with line stores and APB registers.
// Pipeline: a hit passes two register stages, the stage-one registers loaded on acceptance
// of its pixel item and then the result register that drives the master side.
// Throughput: one pixel item per cycle; the line-store RAM read is issued on acceptance and
// its registered data is consumed when stage one advances, with bypass when a column repeats.
// The output register stalls the pipeline only while a hit waits on the master side.
// Reset clears counters, valid flags and registers to their defaults; line stores are
// not cleared and need no clearing pass.
`timescale 1ns / 1ps
module dog_local_max_detector_core #(
  parameter int MAX_WIDTH   = dlmd_pkg::DLMD_MAX_WIDTH,
  parameter int SAMPLE_BITS = dlmd_pkg::DLMD_SAMPLE_BITS,
  localparam int InBits  = ((3 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OutBits = ((2 * dlmd_pkg::DLMD_COORD_BITS + SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Pixel input.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: below_sample, centre_sample, above_sample, zero fill.
  input  logic [InBits-1:0]                   s_axis_tdata,
  // tuser: frame_start.
  input  logic [0:0]                          s_axis_tuser,
  // Hit output.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: hit_row, hit_col, hit_value, zero fill.
  output logic [OutBits-1:0]                  m_axis_tdata,
  // Configuration.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dlmd_pkg::DLMD_ADDR_BITS-1:0] paddr,
  input  logic [dlmd_pkg::DLMD_DATA_BITS-1:0] pwdata,
  output logic [dlmd_pkg::DLMD_DATA_BITS-1:0] prdata,
  output logic                                pready
);

  localparam int S     = SAMPLE_BITS;
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = dlmd_pkg::DLMD_ROW_BITS;
  localparam int OW    = dlmd_pkg::DLMD_COORD_BITS;
  localparam int SZ    = dlmd_pkg::DLMD_SIZE_BITS;
  localparam int TB    = dlmd_pkg::DLMD_THR_BITS;
  localparam int NL    = dlmd_pkg::DLMD_LAYERS;
  localparam int NT    = dlmd_pkg::DLMD_TAPS;
  localparam int WordW = 2 * S * NL;

  // ---------------- configuration registers ----------------
  logic [SZ-1:0] frame_width_q, frame_height_q;
  logic [TB-1:0] contrast_thr_q;
  logic          cfg_write;
  logic [1:0]    cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= dlmd_pkg::FRAME_WIDTH_RESET;
      frame_height_q <= dlmd_pkg::FRAME_HEIGHT_RESET;
      contrast_thr_q <= dlmd_pkg::CONTRAST_THR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dlmd_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[SZ-1:0];
        dlmd_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[SZ-1:0];
        dlmd_pkg::REG_CONTRAST_THR: contrast_thr_q <= pwdata[TB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      dlmd_pkg::REG_FRAME_WIDTH:  prdata = {{(32-SZ){1'b0}}, frame_width_q};
      dlmd_pkg::REG_FRAME_HEIGHT: prdata = {{(32-SZ){1'b0}}, frame_height_q};
      dlmd_pkg::REG_CONTRAST_THR: prdata = {{(32-TB){1'b0}}, contrast_thr_q};
      default:                    prdata = '0;
    endcase
  end

  // Effective frame size, saturated into the legal range.
  logic [CW:0]   width_eff;
  logic [SZ-1:0] height_eff;

  always_comb begin
    if (frame_width_q < SZ'(dlmd_pkg::DLMD_MIN_SIZE)) begin
      width_eff = (CW+1)'(dlmd_pkg::DLMD_MIN_SIZE);
    end else if ({21'd0, frame_width_q} > 32'(MAX_WIDTH)) begin
      width_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      width_eff = (CW+1)'(frame_width_q);
    end
    if (frame_height_q < SZ'(dlmd_pkg::DLMD_MIN_SIZE)) begin
      height_eff = SZ'(dlmd_pkg::DLMD_MIN_SIZE);
    end else if (frame_height_q > SZ'(dlmd_pkg::DLMD_MAX_HEIGHT)) begin
      height_eff = SZ'(dlmd_pkg::DLMD_MAX_HEIGHT);
    end else begin
      height_eff = frame_height_q;
    end
  end

  // Threshold taken as SAMPLE_BITS wide and signed.
  logic [S+TB-1:0]       thr_wide;
  logic signed [S-1:0]   thr_sample;
  assign thr_wide   = {{S{1'b0}}, contrast_thr_q};
  assign thr_sample = signed'(thr_wide[S-1:0]);

  // ---------------- handshake ----------------
  logic out_vld_q;
  logic advance;
  logic accept;

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && advance;

  // ---------------- position counters ----------------
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [CW:0]   col_cur_w, col_nxt_w;
  logic [SZ-1:0] row_cur_w, row_nxt_w;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;

  always_comb begin
    if (s_axis_tuser[0]) begin
      col_cur_w = '0;
      row_cur_w = '0;
    end else begin
      col_cur_w = {1'b0, col_q};
      row_cur_w = SZ'(row_q);
    end
    // A shrunken width or height can leave the counters beyond the frame.
    if (col_cur_w >= width_eff) begin
      col_cur_w = '0;
      row_cur_w = row_cur_w + SZ'(1);
    end
    if (row_cur_w >= height_eff) begin
      row_cur_w = '0;
    end
    col_cur = col_cur_w[CW-1:0];
    row_cur = row_cur_w[RW-1:0];

    col_nxt_w = col_cur_w + (CW+1)'(1);
    row_nxt_w = row_cur_w;
    if (col_nxt_w >= width_eff) begin
      col_nxt_w = '0;
      row_nxt_w = row_nxt_w + SZ'(1);
    end
    if (row_nxt_w >= height_eff) begin
      row_nxt_w = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_nxt_w[CW-1:0];
      row_q <= row_nxt_w[RW-1:0];
    end
  end

  // ---------------- stage one: line-store read returns ----------------
  logic                 s1_vld_q;
  logic [CW-1:0]        s1_col_q;
  logic [RW-1:0]        s1_row_q;
  logic [NL*S-1:0]      s1_fresh_q;
  logic                 s1_fwd_q;
  logic [WordW-1:0]     s1_fwd_data_q;
  logic [WordW-1:0]     ram_rdata;
  logic [WordW-1:0]     lines_used;
  logic [WordW-1:0]     lines_wdata;
  logic                 process;

  assign process = s1_vld_q && advance;

  // Each RAM word holds, per layer, the older row sample and then the newer one.
  dlmd_ram #(
    .WIDTH (WordW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (process),
    .waddr_i (s1_col_q),
    .wdata_i (lines_wdata),
    .re_i    (accept),
    .raddr_i (col_cur),
    .rdata_o (ram_rdata)
  );

  assign lines_used = s1_fwd_q ? s1_fwd_data_q : ram_rdata;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      lines_wdata[l*2*S +: S]     = lines_used[l*2*S+S +: S];
      lines_wdata[l*2*S+S +: S]   = s1_fresh_q[l*S +: S];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q <= accept;
    end
  end

  // The RAM read misses a write to the same column at the same edge; bypass it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q      <= col_cur;
      s1_row_q      <= row_cur;
      s1_fresh_q    <= s_axis_tdata[NL*S-1:0];
      s1_fwd_q      <= process && (s1_col_q == col_cur);
      s1_fwd_data_q <= lines_wdata;
    end
  end

  // ---------------- 3x3x3 window ----------------
  logic [NT*S-1:0] win_q, win_d;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      for (int r = 0; r < 3; r++) begin
        win_d[(l*9+r*3+0)*S +: S] = win_q[(l*9+r*3+1)*S +: S];
        win_d[(l*9+r*3+1)*S +: S] = win_q[(l*9+r*3+2)*S +: S];
      end
      win_d[(l*9+0*3+2)*S +: S] = lines_used[l*2*S +: S];
      win_d[(l*9+1*3+2)*S +: S] = lines_used[l*2*S+S +: S];
      win_d[(l*9+2*3+2)*S +: S] = s1_fresh_q[l*S +: S];
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      win_q <= win_d;
    end
  end

  logic max_hit;
  logic hit;

  dlmd_max_check #(
    .SAMPLE_BITS (S)
  ) u_max_check (
    .window_i    (win_d),
    .threshold_i (thr_sample),
    .hit_o       (max_hit)
  );

  // The window is centred one row and one column behind the arriving pixel.
  assign hit = max_hit && (s1_row_q >= RW'(2)) && (s1_col_q >= CW'(2));

  // ---------------- result register ----------------
  logic [CW-1:0]    col_m1;
  logic [CW+OW-1:0] col_m1_wide;
  logic [OW-1:0]    hit_row_q, hit_col_q;
  logic [S-1:0]     hit_value_q;

  assign col_m1      = s1_col_q - CW'(1);
  assign col_m1_wide = {{OW{1'b0}}, col_m1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= s1_vld_q && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && hit) begin
      hit_row_q   <= OW'(s1_row_q - RW'(1));
      hit_col_q   <= col_m1_wide[OW-1:0];
      hit_value_q <= win_d[dlmd_pkg::DLMD_CENTRE_TAP*S +: S];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutBits-2*OW-S){1'b0}}, hit_value_q, hit_col_q, hit_row_q};

endmodule
